// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the linked list engine RTL.
// No dependencies; expects clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dll_pkg.sv
// Shared types, codes and constants of the linked list engine.
// No dependencies; used by dll_ctrl, dll_dp and the top level.
package dll_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int KEY_W        = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 6;

  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_DEL_KEY   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_TAIL,
    RD_NEXT
  } dll_rd_t;

  typedef struct packed {
    logic                accept;
    logic                rd_en;
    dll_rd_t             rd_sel;
    logic                fs_rd;
    logic                ins_write;
    logic                unlink;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                out_load;
    logic                out_elem;
    logic [STATUS_W-1:0] status;
  } dll_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic walk_end;
    logic out_free;
  } dll_stat_t;

endpackage

// File: hw/rtl/doubly_linked_list_engine.sv
// Doubly linked list engine: list of signed 32-bit keys in node memories.
// Request channel in_valid/in_stall carries in_operation and in_key:
// insert at front, delete by key, delete first, delete last, dump.
// Result channel out_valid/out_stall gives one status result per request,
// or one result per element for a dump (out_last on the final one).
// An insert writes its node and a delete of the first or last node unlinks it
// before the result is loaded; a delete by key walks from the head until a key
// matches (then unlinks that node) or the walk ends; a rejected insert, an empty
// list or an unused operation goes straight to its result; a dump loads its
// elements in list order, head first, as it walks.
// Node walks are set by one registered read of the node memories per cycle.
// One request is worked on at a time; in_stall is high until its last result
// sits in the output register, which then holds while out_stall is high.
// A stalled output holds the walk and the sequencer until it is taken.
// Reset (rst_n low, synchronous) empties the list and frees every node;
// node memories are not cleared, and no clearing pass is needed.
// Depends on dll_pkg, dll_ctrl and dll_dp.
module doubly_linked_list_engine import dll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_operation,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     out_status,
  output logic signed [KEY_W-1:0] out_key_out,
  output logic                    out_element_valid,
  output logic                    out_last,
  output logic [COUNT_W-1:0]      out_entry_count
);

  dll_cmd_t  cmd;
  dll_stat_t stat;

  dll_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  dll_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_key            (in_key),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_key_out       (out_key_out),
    .out_element_valid (out_element_valid),
    .out_last          (out_last),
    .out_entry_count   (out_entry_count)
  );

endmodule

// File: hw/rtl/dll_dp.sv
// Datapath of the linked list engine: node memories, free-index stack,
// list pointers, walk counter and result register. Depends on dll_pkg.
`include "assert_macros.svh"
module dll_dp import dll_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dll_cmd_t                   cmd,
  input  logic signed [KEY_W-1:0]    in_key,
  output dll_stat_t                  stat,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [KEY_W-1:0]    out_key_out,
  output logic                       out_element_valid,
  output logic                       out_last,
  output logic [COUNT_W-1:0]         out_entry_count
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [KEY_W-1:0] node_key  [CAPACITY];
  logic [IW-1:0]           node_next [CAPACITY];
  logic [IW-1:0]           node_prev [CAPACITY];
  logic [IW-1:0]           free_stack[CAPACITY];

  logic [CAPACITY-1:0]     fs_vld_r;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_rd_r;
  logic [IW-1:0]           nxt_rd_r, prv_rd_r, cur_r;
  logic [IW-1:0]           fs_rd_r;
  logic                    fsv_rd_r;
  logic [IW-1:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]           count_r, count_nxt, ftop_r, ftop_nxt;
  logic [IW-1:0]           walk_r;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic signed [KEY_W-1:0] out_key_r;
  logic                    out_ev_r, out_last_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic [IW-1:0] raddr, fs_ra, fs_wa, alloc;
  logic          empty, single, walk_end;
  logic          nx_we, pv_we;
  logic [IW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

  assign empty    = (count_r == '0);
  assign single   = (count_r == CW'(1));
  assign walk_end = (CW'(walk_r) == count_r - 1'b1);
  assign fs_ra    = IW'(ftop_r - 1'b1);
  assign fs_wa    = IW'(ftop_r);
  assign alloc    = fsv_rd_r ? fs_rd_r : fs_ra;

  assign stat.empty    = empty;
  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.match    = (key_rd_r == key_r);
  assign stat.walk_end = walk_end;
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD: raddr = head_r;
      RD_TAIL: raddr = tail_r;
      RD_NEXT: raddr = nxt_rd_r;
      default: raddr = head_r;
    endcase
  end

  always_comb begin
    nx_we = cmd.ins_write || (cmd.unlink && !single && head_r != cur_r);
    nx_wa = cmd.ins_write ? alloc : prv_rd_r;
    nx_wd = cmd.ins_write ? (empty ? alloc : head_r) : nxt_rd_r;
    pv_we = (cmd.ins_write && !empty) || (cmd.unlink && !single && tail_r != cur_r);
    pv_wa = cmd.ins_write ? head_r : nxt_rd_r;
    pv_wd = cmd.ins_write ? alloc : prv_rd_r;
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ftop_nxt  = ftop_r;
    if (cmd.ins_write) begin
      head_nxt  = alloc;
      if (empty) begin
        tail_nxt = alloc;
      end
      count_nxt = count_r + 1'b1;
      ftop_nxt  = ftop_r - 1'b1;
    end else if (cmd.unlink) begin
      if (single) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else begin
        if (head_r == cur_r) begin
          head_nxt = nxt_rd_r;
        end
        if (tail_r == cur_r) begin
          tail_nxt = prv_rd_r;
        end
      end
      count_nxt = count_r - 1'b1;
      ftop_nxt  = ftop_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      node_key[alloc] <= key_r;
    end
    if (nx_we) begin
      node_next[nx_wa] <= nx_wd;
    end
    if (pv_we) begin
      node_prev[pv_wa] <= pv_wd;
    end
    if (cmd.unlink) begin
      free_stack[fs_wa] <= cur_r;
    end
    if (cmd.rd_en) begin
      key_rd_r <= node_key[raddr];
      nxt_rd_r <= node_next[raddr];
      prv_rd_r <= node_prev[raddr];
      cur_r    <= raddr;
    end
    if (cmd.fs_rd) begin
      fs_rd_r  <= free_stack[fs_ra];
      fsv_rd_r <= fs_vld_r[fs_ra];
    end
    if (cmd.accept) begin
      key_r <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      ftop_r   <= CW'(CAPACITY);
      fs_vld_r <= '0;
      walk_r   <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ftop_r  <= ftop_nxt;
      if (cmd.unlink) begin
        fs_vld_r[fs_wa] <= 1'b1;
      end
      if (cmd.cnt_clr) begin
        walk_r <= '0;
      end else if (cmd.cnt_inc) begin
        walk_r <= walk_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_elem ? ST_OK : cmd.status;
      out_key_r    <= cmd.out_elem ? key_rd_r : '0;
      out_ev_r     <= cmd.out_elem;
      out_last_r   <= cmd.out_elem ? walk_end : 1'b1;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_key_out       = out_key_r;
  assign out_element_valid = out_ev_r;
  assign out_last          = out_last_r;
  assign out_entry_count   = out_count_r;

  `ASSERT_ALWAYS(a_pool_balance, (CW+1)'(count_r) + (CW+1)'(ftop_r) == (CW+1)'(CAPACITY), "node pool out of balance")
  `ASSERT_IMPLIES(a_ins_room, cmd.ins_write, !stat.full && ftop_r != '0, "insert into full pool")

endmodule

// File: hw/rtl/dll_ctrl.sv
// Controller of the linked list engine: decodes each request and sequences
// reads, walks, writes and results. Depends on dll_pkg.
`include "assert_macros.svh"
module dll_ctrl import dll_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_stall,
  input  dll_stat_t       stat,
  output dll_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WR,
    S_SEARCH,
    S_UNLINK,
    S_RESP,
    S_DUMP
  } state_t;

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.status = status_r;
    state_nxt  = state_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_operation) inside
            OP_INSERT: begin
              if (stat.full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                cmd.fs_rd = 1'b1;
                state_nxt = S_INS_WR;
              end
            end
            OP_DEL_KEY, OP_DUMP: begin
              if (stat.empty) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_HEAD;
                cmd.cnt_clr = 1'b1;
                state_nxt   = (in_operation == OP_DUMP) ? S_DUMP : S_SEARCH;
              end
            end
            OP_DEL_FIRST, OP_DEL_LAST: begin
              if (stat.empty) begin
                status_nxt = ST_MISS;
                state_nxt  = S_RESP;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = (in_operation == OP_DEL_LAST) ? RD_TAIL : RD_HEAD;
                state_nxt  = S_UNLINK;
              end
            end
            default: begin
              status_nxt = ST_MISS;
              state_nxt  = S_RESP;
            end
          endcase
        end
      end
      S_INS_WR: begin
        cmd.ins_write = 1'b1;
        status_nxt    = ST_OK;
        state_nxt     = S_RESP;
      end
      S_SEARCH: begin
        if (stat.match) begin
          state_nxt = S_UNLINK;
        end else if (stat.walk_end) begin
          status_nxt = ST_MISS;
          state_nxt  = S_RESP;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_NEXT;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_elem = 1'b1;
          if (stat.walk_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_NEXT;
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  `ASSERT_IMPLIES(a_unlink_nonempty, cmd.unlink, !stat.empty, "unlink on empty list")
  `ASSERT_IMPLIES(a_walk_nonempty, state_r == S_SEARCH || state_r == S_DUMP, !stat.empty, "walk over empty list")
  `ASSERT_IMPLIES(a_load_free, cmd.out_load, stat.out_free, "result register overwritten")

endmodule

// File: test/tb_doubly_linked_list_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for doubly_linked_list_engine: directed, back-pressure
// and random request traffic checked against an in-bench list predictor.
// Depends on dll_pkg and the doubly_linked_list_engine RTL.
module tb_doubly_linked_list_engine;
  import dll_pkg::*;

  localparam int DEPTH       = CAPACITY_DEF;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] key;
    logic                    elem;
    logic                    last;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_operation = OP_INSERT;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STATUS_W-1:0]     out_status;
  logic signed [KEY_W-1:0] out_key_out;
  logic                    out_element_valid;
  logic                    out_last;
  logic [COUNT_W-1:0]      out_entry_count;

  // predicted list state
  logic signed [KEY_W-1:0] lst_key  [DEPTH];
  logic [IDX_W-1:0]        lst_next [DEPTH];
  logic [IDX_W-1:0]        lst_prev [DEPTH];
  logic [IDX_W-1:0]        free_idx [DEPTH];
  logic [IDX_W-1:0]        lst_head;
  logic [IDX_W-1:0]        lst_tail;
  int                      lst_count;
  int                      free_depth;

  list_result_t pending_results[$];

  int error_count    = 0;
  int requests_sent  = 0;
  int results_checked = 0;
  int full_rejects   = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_pending   = 0;
  int hold_left      = 0;

  doubly_linked_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_key_out       (out_key_out),
    .out_element_valid (out_element_valid),
    .out_last          (out_last),
    .out_entry_count   (out_entry_count)
  );

  always #4 clk = ~clk;

  function automatic void list_reset();
    for (int i = 0; i < DEPTH; i++) begin
      lst_key[i]  = '0;
      lst_next[i] = '0;
      lst_prev[i] = '0;
      free_idx[i] = IDX_W'(i);
    end
    free_depth = DEPTH;
    lst_head   = '0;
    lst_tail   = '0;
    lst_count  = 0;
  endfunction

  function automatic void expect_result(logic [STATUS_W-1:0] status,
                                        logic signed [KEY_W-1:0] key,
                                        logic elem, logic last);
    list_result_t r;
    r.status = status;
    r.key    = key;
    r.elem   = elem;
    r.last   = last;
    r.count  = COUNT_W'(lst_count);
    pending_results.push_back(r);
  endfunction

  function automatic void unlink_node(logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nx;
    logic [IDX_W-1:0] pv;
    nx = lst_next[idx];
    pv = lst_prev[idx];
    if (lst_count == 1) begin
      lst_head = '0;
      lst_tail = '0;
    end else begin
      if (lst_head == idx) lst_head = nx;
      else lst_next[pv] = nx;
      if (lst_tail == idx) lst_tail = pv;
      else lst_prev[nx] = pv;
    end
    lst_count--;
    if (free_depth < DEPTH) begin
      free_idx[free_depth] = idx;
      free_depth++;
    end
  endfunction

  function automatic void predict_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    logic [IDX_W-1:0]    cur;
    logic [STATUS_W-1:0] status;
    logic                hit;
    status = ST_OK;
    hit    = 1'b0;
    case (op)
      OP_INSERT: begin
        if (lst_count >= DEPTH || free_depth == 0) begin
          status = ST_FULL;
          full_rejects++;
        end else begin
          free_depth--;
          cur = free_idx[free_depth];
          lst_key[cur]  = key;
          lst_prev[cur] = cur;
          if (lst_count == 0) begin
            lst_next[cur] = cur;
            lst_tail      = cur;
          end else begin
            lst_next[cur]      = lst_head;
            lst_prev[lst_head] = cur;
          end
          lst_head = cur;
          lst_count++;
        end
      end
      OP_DEL_KEY: begin
        status = ST_MISS;
        cur    = lst_head;
        for (int n = 0; n < lst_count && !hit; n++) begin
          if (lst_key[cur] == key) begin
            unlink_node(cur);
            status = ST_OK;
            hit    = 1'b1;
          end else begin
            cur = lst_next[cur];
          end
        end
      end
      OP_DEL_FIRST: begin
        if (lst_count == 0) status = ST_MISS;
        else unlink_node(lst_head);
      end
      OP_DEL_LAST: begin
        if (lst_count == 0) status = ST_MISS;
        else unlink_node(lst_tail);
      end
      OP_DUMP: begin
        if (lst_count == 0) begin
          status = ST_MISS;
        end else begin
          cur = lst_head;
          for (int n = 0; n < lst_count; n++) begin
            expect_result(ST_OK, lst_key[cur], 1'b1, n + 1 == lst_count);
            cur = lst_next[cur];
          end
          return;
        end
      end
      default: status = ST_MISS;
    endcase
    expect_result(status, '0, 1'b0, 1'b1);
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_listed_key();
    logic [IDX_W-1:0] cur;
    int               steps;
    cur   = lst_head;
    steps = $urandom_range(lst_count - 1);
    repeat (steps) cur = lst_next[cur];
    return lst_key[cur];
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(15) - 8;
      1: return ($urandom_range(1) != 0) ? KEY_MIN : KEY_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic void check_field(string field, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, key);
    requests_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_request(OP_DUMP, '0);
    send_request(OP_DEL_FIRST, '0);
    send_request(OP_DEL_LAST, '0);
    send_request(OP_DEL_KEY, KEY_MIN);
    send_request(OP_UNUSED_LO, KEY_MAX);
    send_request(OP_UNUSED_HI, -1);
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, 0);
    send_request(OP_INSERT, -1);
    send_request(OP_INSERT, 7);
    send_request(OP_INSERT, 9);
    send_request(OP_INSERT, 7);
    send_request(OP_DUMP, '0);
    send_request(OP_DEL_KEY, 7);
    send_request(OP_DEL_KEY, KEY_MAX);
    send_request(OP_DEL_KEY, KEY_MIN);
    send_request(OP_DEL_KEY, 12345);
    send_request(OP_DEL_FIRST, '0);
    send_request(OP_DEL_LAST, '0);
    send_request(OP_DUMP, '0);
  endtask

  task automatic test_full_list_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (lst_count > 0) send_request(OP_DEL_FIRST, '0);
    hold_pending = 150;
    while (lst_count < DEPTH) send_request(OP_INSERT, pick_key());
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_DUMP, '0);
  endtask

  task automatic test_random_traffic(int items, int s_idle, int r_idle);
    int                      r;
    logic signed [KEY_W-1:0] k;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        send_request(OP_INSERT, pick_key());
      end else if (r < 65) begin
        if (lst_count > 0 && $urandom_range(3) != 0) k = pick_listed_key();
        else k = pick_key();
        send_request(OP_DEL_KEY, k);
      end else if (r < 75) begin
        send_request(OP_DEL_FIRST, $urandom);
      end else if (r < 85) begin
        send_request(OP_DEL_LAST, $urandom);
      end else if (r < 96) begin
        send_request(OP_DUMP, $urandom);
      end else begin
        send_request(OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)), $urandom);
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_pending > 0) begin
      hold_left    = hold_pending;
      hold_pending = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d key %0d",
                 $time, out_status, out_key_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("key_out", 64'(want.key), 64'(out_key_out));
        check_field("element_valid", 64'(want.elem), 64'(out_element_valid));
        check_field("last", 64'(want.last), 64'(out_last));
        check_field("entry_count", 64'(want.count), 64'(out_entry_count));
        results_checked++;
      end
    end
  end

  always @(posedge clk) cycle_count++;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             pending_results.size());
    $display("doubly_linked_list_engine regression: fail");
    $finish;
  end

  initial begin
    list_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_key_extremes();
    test_full_list_backpressure();
    test_random_traffic(22, 26, 54);
    test_random_traffic(22, 54, 26);
    test_random_traffic(22, 0, 0);
    wait_drain();
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("ran %0d requests (empty list, key extremes, full list under back-pressure,",
             requests_sent);
    $display("random traffic): %0d results checked, %0d inserts rejected as full",
             results_checked, full_rejects);
    if (error_count == 0) begin
      $display("doubly_linked_list_engine regression: pass");
    end else begin
      $display("doubly_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
